>>> rtl/pcs_pkg.sv
// Shared constants, types and command/status structs of the PLL coefficient search unit.
package pcs_pkg;

  localparam int unsigned TGT_W    = 20;
  localparam int unsigned REF_W    = 17;
  localparam int unsigned VCO_CFG_W = 20;
  localparam int unsigned P_W      = 3;
  localparam int unsigned M_W      = 8;
  localparam int unsigned N_W      = 8;
  localparam int unsigned VCO_W    = TGT_W + (1 << P_W) - 1;  // target << 7 at most
  localparam int unsigned PROD1_W  = VCO_W + M_W;
  localparam int unsigned PROD2_W  = REF_W + N_W;
  localparam int unsigned DIV_CNT_W = $clog2(PROD2_W + 1);
  localparam int unsigned COEF_W   = 19;
  localparam int unsigned ERR_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam int unsigned POST_DIV_STEPS_DEF = 8;
  localparam int unsigned MAX_REF_DIV_DEF    = 13;
  localparam int unsigned MAX_FEEDBACK_DEF   = 255;

  localparam logic [REF_W-1:0]     REFCLK_RST  = REF_W'(27000);
  localparam logic [VCO_CFG_W-1:0] VCO_MIN_RST = VCO_CFG_W'(128000);
  localparam logic [VCO_CFG_W-1:0] VCO_MAX_RST = VCO_CFG_W'(700000);
  localparam logic [ERR_W-1:0]     ERR_SAT     = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_REFCLK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VCO_MAX = 2'd2;

  // quotient bits per division: n is known below 256, the achieved rate is full width
  localparam logic [DIV_CNT_W-1:0] DIV1_BITS = DIV_CNT_W'(N_W);
  localparam logic [DIV_CNT_W-1:0] DIV2_BITS = DIV_CNT_W'(PROD2_W);

  typedef struct packed {
    logic load;
    logic p_inc;
    logic m_inc;
    logic mul1;
    logic div1_start;
    logic mul2;
    logic div2_start;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_window;
    logic n_over;
    logic n_low;
    logic div_busy;
    logic p_last;
    logic m_last;
  } dp_status_t;

  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [M_W-1:0]   m;
    logic [P_W-1:0]   p;
    logic [ERR_W-1:0] err;
    logic             found;
  } result_t;

endpackage

>>> rtl/pcs_divider.sv
// Restoring divider, one quotient bit per cycle, preloadable partial remainder.
module pcs_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pcs_pkg::REF_W-1:0]     rem_init_i,
  input  logic [pcs_pkg::PROD2_W-1:0]   dividend_i,
  input  logic [pcs_pkg::DIV_CNT_W-1:0] nbits_i,
  input  logic [pcs_pkg::REF_W-1:0]     divisor_i,
  output logic                          busy_o,
  output logic [pcs_pkg::PROD2_W-1:0]   quotient_o
);
  import pcs_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [REF_W-1:0]     rem_q, rem_d;
  logic [PROD2_W-1:0]   sh_q, sh_d;
  logic [PROD2_W-1:0]   quo_q, quo_d;
  logic [REF_W-1:0]     div_q, div_d;
  logic [REF_W:0]       trial;
  logic                 ge;

  assign trial = {rem_q, sh_q[PROD2_W-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nbits_i;
      rem_d  = rem_init_i;
      sh_d   = dividend_i;
      quo_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? REF_W'(trial - {1'b0, div_q}) : trial[REF_W-1:0];
      sh_d  = {sh_q[PROD2_W-2:0], 1'b0};
      quo_d = {quo_q[PROD2_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/pcs_datapath.sv
// Trial counters, multipliers, shared divider and best-candidate registers.
module pcs_datapath #(
  parameter int unsigned POST_DIV_STEPS = pcs_pkg::POST_DIV_STEPS_DEF,
  parameter int unsigned MAX_REF_DIV    = pcs_pkg::MAX_REF_DIV_DEF,
  parameter int unsigned MAX_FEEDBACK   = pcs_pkg::MAX_FEEDBACK_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcs_pkg::ctrl_cmd_t            cmd_i,
  output pcs_pkg::dp_status_t           status_o,
  input  logic [pcs_pkg::TGT_W-1:0]     target_i,
  input  logic [pcs_pkg::REF_W-1:0]     refclk_i,
  input  logic [pcs_pkg::VCO_CFG_W-1:0] vco_min_i,
  input  logic [pcs_pkg::VCO_CFG_W-1:0] vco_max_i,
  output pcs_pkg::result_t              result_o
);
  import pcs_pkg::*;

  logic [TGT_W-1:0]   target_q;
  logic [P_W-1:0]     p_q, p_d;
  logic [M_W-1:0]     m_q, m_d;
  logic [N_W-1:0]     n_q;
  logic [PROD1_W-1:0] prod1_q;
  logic [PROD2_W-1:0] prod2_q;
  logic               have_q, have_d;
  logic [PROD2_W-1:0] berr_q;
  logic [N_W-1:0]     bn_q;
  logic [M_W-1:0]     bm_q;
  logic [P_W-1:0]     bp_q;

  logic [VCO_W-1:0]     vco;
  logic [PROD2_W-1:0]   act;
  logic [PROD2_W-1:0]   tgt_ext;
  logic [PROD2_W-1:0]   diff;
  logic                 better;
  logic                 div_start;
  logic [REF_W-1:0]     div_rem_init;
  logic [PROD2_W-1:0]   div_dividend;
  logic [DIV_CNT_W-1:0] div_nbits;
  logic [REF_W-1:0]     div_divisor;
  logic                 div_busy;
  logic [PROD2_W-1:0]   quotient;

  assign vco = VCO_W'(target_q) << p_q;

  assign status_o.in_window = (vco >= VCO_W'(vco_min_i)) && (vco <= VCO_W'(vco_max_i));
  // n fits in 8 bits exactly when vco*m < refclk*256
  assign status_o.n_over    = prod1_q >= PROD1_W'({refclk_i, {N_W{1'b0}}});
  assign status_o.n_low     = (quotient[N_W-1:0] < N_W'(2))
                           || (quotient[N_W-1:0] > N_W'(MAX_FEEDBACK));
  assign status_o.div_busy  = div_busy;
  assign status_o.p_last    = p_q == P_W'(POST_DIV_STEPS - 1);
  assign status_o.m_last    = m_q == M_W'(MAX_REF_DIV);

  assign div_start    = cmd_i.div1_start | cmd_i.div2_start;
  assign div_rem_init = cmd_i.div1_start ? prod1_q[REF_W+N_W-1:N_W] : '0;
  assign div_dividend = cmd_i.div1_start ? {prod1_q[N_W-1:0], {REF_W{1'b0}}} : prod2_q;
  assign div_nbits    = cmd_i.div1_start ? DIV1_BITS : DIV2_BITS;
  assign div_divisor  = cmd_i.div1_start ? refclk_i : REF_W'(m_q);

  pcs_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rem_init_i(div_rem_init),
    .dividend_i(div_dividend),
    .nbits_i   (div_nbits),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quotient_o(quotient)
  );

  assign act     = quotient >> p_q;
  assign tgt_ext = PROD2_W'(target_q);
  assign diff    = (act > tgt_ext) ? (act - tgt_ext) : (tgt_ext - act);
  assign better  = !have_q || (diff < berr_q);

  always_comb begin
    p_d    = p_q;
    m_d    = m_q;
    have_d = have_q;
    if (cmd_i.load) begin
      p_d    = '0;
      m_d    = M_W'(1);
      have_d = 1'b0;
    end else begin
      if (cmd_i.p_inc) begin
        p_d = p_q + 1'b1;
        m_d = M_W'(1);
      end else if (cmd_i.m_inc) begin
        m_d = m_q + 1'b1;
      end
      if (cmd_i.update && better) begin
        have_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q    <= '0;
      m_q    <= M_W'(1);
      have_q <= 1'b0;
    end else begin
      p_q    <= p_d;
      m_q    <= m_d;
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= target_i;
      bn_q     <= N_W'(1);
      bm_q     <= M_W'(1);
      bp_q     <= '0;
      berr_q   <= PROD2_W'(ERR_SAT);
    end else if (cmd_i.update && better) begin
      bn_q   <= n_q;
      bm_q   <= m_q;
      bp_q   <= p_q;
      berr_q <= diff;
    end
    if (cmd_i.mul1) begin
      prod1_q <= PROD1_W'(vco) * PROD1_W'(m_q);
    end
    if (cmd_i.mul2) begin
      n_q     <= quotient[N_W-1:0];
      prod2_q <= PROD2_W'(refclk_i) * PROD2_W'(quotient[N_W-1:0]);
    end
  end

  assign result_o.n     = bn_q;
  assign result_o.m     = bm_q;
  assign result_o.p     = bp_q;
  assign result_o.err   = (berr_q > PROD2_W'(ERR_SAT)) ? ERR_SAT : berr_q[ERR_W-1:0];
  assign result_o.found = have_q;

endmodule

>>> rtl/pcs_ctrl.sv
// Sequencer that walks the p/m trial loops and drives the datapath.
module pcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  output logic                out_push_o,
  output pcs_pkg::ctrl_cmd_t  cmd_o,
  input  pcs_pkg::dp_status_t status_i
);
  import pcs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PCHK = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_NCHK = 4'd3;
  localparam logic [3:0] S_DIV1 = 4'd4;
  localparam logic [3:0] S_NRNG = 4'd5;
  localparam logic [3:0] S_D2ST = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_MNXT = 4'd9;
  localparam logic [3:0] S_PNXT = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_push_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PCHK;
        end
      end
      S_PCHK: begin
        state_d = status_i.in_window ? S_MUL1 : S_PNXT;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_NCHK;
      end
      S_NCHK: begin
        if (status_i.n_over) begin
          state_d = S_MNXT;
        end else begin
          cmd_o.div1_start = 1'b1;
          state_d          = S_DIV1;
        end
      end
      S_DIV1: begin
        if (!status_i.div_busy) begin
          state_d = S_NRNG;
        end
      end
      S_NRNG: begin
        if (status_i.n_low) begin
          state_d = S_MNXT;
        end else begin
          cmd_o.mul2 = 1'b1;
          state_d    = S_D2ST;
        end
      end
      S_D2ST: begin
        cmd_o.div2_start = 1'b1;
        state_d          = S_DIV2;
      end
      S_DIV2: begin
        if (!status_i.div_busy) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.update = 1'b1;
        state_d      = S_MNXT;
      end
      S_MNXT: begin
        if (status_i.m_last) begin
          state_d = S_PNXT;
        end else begin
          cmd_o.m_inc = 1'b1;
          state_d     = S_MUL1;
        end
      end
      S_PNXT: begin
        if (status_i.p_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.p_inc = 1'b1;
          state_d     = S_PCHK;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          out_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div1_start || cmd_o.div2_start) |-> !status_i.div_busy)
    else $error("divider started while busy");

  a_update_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> !status_i.div_busy && $past(state_q == S_DIV2))
    else $error("candidate compared before division finished");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken during a search");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> out_free_i && !in_ready_o)
    else $error("result pushed into an occupied output register");
`endif

endmodule

>>> rtl/pll_coefficient_search_unit.sv
// Top level: configuration registers, output register, sequencer and datapath.
//
//  channel   | direction | signals                      | payload
//  s_axis    | in        | tvalid tready tdata[23:0]    | target frequency
//  m_axis    | out       | tvalid tready tdata tuser    | n, m, p, coef_word, error_khz / found
//  cfg       | in        | cfg_valid/ready index data   | refclk, vco_min, vco_max
//
// One request at a time. A full (p, m) trial runs two divisions on the shared one-bit-per-cycle
// divider (8 quotient bits for n, 25 for the achieved rate); n out of range ends a trial before the second division.
// The next request is taken once the result is in the output register, even if m_axis stalls.
// No clearing pass after reset; registers come up at their reset values.
module pll_coefficient_search_unit #(
  parameter int unsigned POST_DIV_STEPS = pcs_pkg::POST_DIV_STEPS_DEF,
  parameter int unsigned MAX_REF_DIV    = pcs_pkg::MAX_REF_DIV_DEF,
  parameter int unsigned MAX_FEEDBACK   = pcs_pkg::MAX_FEEDBACK_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pcs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [19:0] target frequency
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] feedback_mult, [11:8] ref_divider, [14:12] post_div_log,
  // [33:15] coef_word, [53:34] error_khz, [55:54] zero
  output logic [pcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,   // [0] found
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import pcs_pkg::*;

  logic [REF_W-1:0]     refclk_q;
  logic [VCO_CFG_W-1:0] vco_min_q;
  logic [VCO_CFG_W-1:0] vco_max_q;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q;
  result_t              result;
  ctrl_cmd_t            cmd;
  dp_status_t           status;
  logic                 out_free;
  logic                 out_push;
  logic                 cfg_we;
  logic [COEF_W-1:0]    coef;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refclk_q  <= REFCLK_RST;
      vco_min_q <= VCO_MIN_RST;
      vco_max_q <= VCO_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_REFCLK:  refclk_q  <= cfg_data_i[REF_W-1:0];
        CFG_VCO_MIN: vco_min_q <= cfg_data_i;
        CFG_VCO_MAX: vco_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .out_free_i(out_free),
    .out_push_o(out_push),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  pcs_datapath #(
    .POST_DIV_STEPS(POST_DIV_STEPS),
    .MAX_REF_DIV   (MAX_REF_DIV),
    .MAX_FEEDBACK  (MAX_FEEDBACK)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .target_i (s_axis_tdata[TGT_W-1:0]),
    .refclk_i (refclk_q),
    .vco_min_i(vco_min_q),
    .vco_max_i(vco_max_q),
    .result_o (result)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_push) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_q <= result;
    end
  end

  assign coef          = {out_q.p, out_q.n, out_q.m};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.err, coef, out_q.p, out_q.m[3:0], out_q.n};
  assign m_axis_tuser  = out_q.found;

endmodule

>>> tb/sv/testbench.sv
// Testbench for the PLL coefficient search unit: directed table plus random requests.
module testbench;
  import pcs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned RX_HOLD_CYCLES = 6000;
  localparam int unsigned DRAIN_CYCLES   = 4500;
  localparam int unsigned RAND_PHASES    = 8;
  localparam int unsigned PHASE_REQUESTS = 50;

  typedef struct packed {
    logic [7:0]  n;
    logic [3:0]  m;
    logic [2:0]  p;
    logic [18:0] coef;
    logic [19:0] err;
    logic        found;
  } coef_result_t;

  // n, m, p, coef_word, error_khz, found
  localparam coef_result_t NO_CANDIDATE = {8'd1, 4'd1, 3'd0, 19'h00101, 20'hFFFFF, 1'b0};
  localparam coef_result_t EXACT_27MHZ  = {8'd8, 4'd1, 3'd3, 19'h30801, 20'd0, 1'b1};
  localparam coef_result_t UNIT_REFCLK  = {8'd2, 4'd2, 3'd0, 19'h00202, 20'd0, 1'b1};

  typedef enum logic { ROW_CFG, ROW_TARGET } row_kind_e;
  typedef enum logic [1:0] { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [TGT_W-1:0]       target;
    bit                     typed;
    coef_result_t           want;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // mirror of the block's registers
  logic [REF_W-1:0]     cfg_refclk  = REFCLK_RST;
  logic [VCO_CFG_W-1:0] cfg_vco_min = VCO_MIN_RST;
  logic [VCO_CFG_W-1:0] cfg_vco_max = VCO_MAX_RST;

  coef_result_t expected_results[$];
  stim_row_t    directed_rows[$];
  idle_mode_e   idle_mode = IDLE_NONE;
  int unsigned  mismatch_count = 0;
  int unsigned  hold_requests = 0;
  int unsigned  holds_served = 0;
  int unsigned  rx_hold_left = 0;

  pll_coefficient_search_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Walks p outermost, m inner; first strictly smaller error wins.
  function automatic coef_result_t search_coefficients(input logic [TGT_W-1:0] target);
    coef_result_t     r;
    longint unsigned  vco, n, act, diff, best_err;
    bit               have;
    r = NO_CANDIDATE;
    best_err = 64'hFFFFF;
    have = 1'b0;
    if (cfg_refclk != 0) begin
      for (int p = 0; p < POST_DIV_STEPS_DEF; p++) begin
        vco = 64'(target) << p;
        if (vco < cfg_vco_min || vco > cfg_vco_max) continue;
        for (int m = 1; m <= MAX_REF_DIV_DEF; m++) begin
          n = (vco * 64'(m)) / 64'(cfg_refclk);
          if (n < 2 || n > MAX_FEEDBACK_DEF) continue;
          act = ((64'(cfg_refclk) * n) / 64'(m)) >> p;
          diff = (act > 64'(target)) ? act - 64'(target) : 64'(target) - act;
          if (!have || diff < best_err) begin
            have = 1'b1;
            best_err = diff;
            r.n = n[7:0];
            r.m = 4'(m);
            r.p = 3'(p);
          end
        end
      end
    end
    r.coef = {r.p, r.n, 8'(r.m)};
    r.err = (best_err > 64'hFFFFF) ? ERR_SAT : best_err[19:0];
    r.found = have;
    return r;
  endfunction

  // Mostly targets that land inside the VCO window for some p; the rest is noise.
  function automatic logic [TGT_W-1:0] pick_target();
    logic [VCO_CFG_W-1:0] vco;
    int unsigned          sel;
    int unsigned          p;
    sel = $urandom_range(0, 99);
    p = $urandom_range(0, POST_DIV_STEPS_DEF - 1);
    if (sel < 20 || cfg_vco_min > cfg_vco_max) return TGT_W'($urandom);
    if (sel < 30) return ($urandom_range(0, 1) != 0) ? cfg_vco_max : cfg_vco_min;
    vco = VCO_CFG_W'($urandom_range(cfg_vco_min, cfg_vco_max));
    return vco >> p;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic add_cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = data;
    row.target = '0;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_target_row(input logic [TGT_W-1:0] target, input bit typed,
                                input coef_result_t want);
    stim_row_t row;
    row.kind = ROW_TARGET;
    row.idx = '0;
    row.data = '0;
    row.target = target;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_REFCLK:  cfg_refclk = data[REF_W-1:0];
      CFG_VCO_MIN: cfg_vco_min = data;
      CFG_VCO_MAX: cfg_vco_max = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_target(input logic [TGT_W-1:0] target, input bit typed,
                             input coef_result_t want);
    int unsigned gap;
    int unsigned rate;
    gap = 0;
    rate = (idle_mode == IDLE_SENDER) ? 57 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    while ($urandom_range(0, 99) < rate) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'(target);
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(typed ? want : search_coefficients(target));
  endtask

  // Receiver: random stalls per phase, plus a long hold-off on request.
  always @(negedge clk_i) begin
    int unsigned rate;
    rate = (idle_mode == IDLE_RECEIVER) ? 57 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      rx_hold_left = RX_HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rate);
    end
  end

  always @(posedge clk_i) begin
    coef_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected, tdata=%h", m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[7:0] !== want.n)
          flag_mismatch($sformatf("feedback_mult %0d, want %0d", m_axis_tdata[7:0], want.n));
        if (m_axis_tdata[11:8] !== want.m)
          flag_mismatch($sformatf("ref_divider %0d, want %0d", m_axis_tdata[11:8], want.m));
        if (m_axis_tdata[14:12] !== want.p)
          flag_mismatch($sformatf("post_div_log %0d, want %0d", m_axis_tdata[14:12], want.p));
        if (m_axis_tdata[33:15] !== want.coef)
          flag_mismatch($sformatf("coef_word %h, want %h", m_axis_tdata[33:15], want.coef));
        if (m_axis_tdata[53:34] !== want.err)
          flag_mismatch($sformatf("error_khz %0d, want %0d", m_axis_tdata[53:34], want.err));
        if (m_axis_tuser !== want.found)
          flag_mismatch($sformatf("found %b, want %b", m_axis_tuser, want.found));
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] refclk_data, vmin, vmax;

    // reset settings
    add_target_row(20'd0, 1'b1, NO_CANDIDATE);
    add_target_row(20'hFFFFF, 1'b1, NO_CANDIDATE);
    add_target_row(20'd128000, 1'b0, '0);
    add_target_row(20'd700000, 1'b0, '0);
    add_target_row(20'd700001, 1'b1, NO_CANDIDATE);
    add_target_row(20'd1000, 1'b0, '0);
    add_target_row(20'd27000, 1'b1, EXACT_27MHZ);
    // write to a nonexistent register changes nothing
    add_cfg_row(CFG_UNUSED, 20'hFFFFF);
    add_target_row(20'd27000, 1'b1, EXACT_27MHZ);
    // zero reference clock, directly and through the 17-bit mask
    add_cfg_row(CFG_REFCLK, 20'h00000);
    add_target_row(20'd200000, 1'b1, NO_CANDIDATE);
    add_cfg_row(CFG_REFCLK, 20'h20000);
    add_target_row(20'd300000, 1'b1, NO_CANDIDATE);
    add_cfg_row(CFG_REFCLK, 20'hFFFFF);
    add_target_row(20'd500000, 1'b0, '0);
    // inverted VCO window
    add_cfg_row(CFG_REFCLK, 20'd27000);
    add_cfg_row(CFG_VCO_MIN, 20'hFFFFF);
    add_cfg_row(CFG_VCO_MAX, 20'h00000);
    add_target_row(20'd27000, 1'b1, NO_CANDIDATE);
    add_target_row(20'd0, 1'b1, NO_CANDIDATE);
    // full window, 1 kHz reference
    add_cfg_row(CFG_REFCLK, 20'd1);
    add_cfg_row(CFG_VCO_MIN, 20'h00000);
    add_cfg_row(CFG_VCO_MAX, 20'hFFFFF);
    add_target_row(20'd1, 1'b1, UNIT_REFCLK);
    add_target_row(20'd0, 1'b1, NO_CANDIDATE);
    add_target_row(20'hFFFFF, 1'b1, NO_CANDIDATE);
    add_cfg_row(CFG_REFCLK, 20'd100000);
    add_target_row(20'hFFFFF, 1'b0, '0);
    add_target_row(20'd524288, 1'b0, '0);
    add_target_row(20'd65537, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_register(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_target(directed_rows[i].target, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      idle_mode = idle_mode_e'(ph % 4);
      refclk_data = CFG_DATA_W'($urandom_range(1000, 100000))
                  | (CFG_DATA_W'($urandom_range(0, 7)) << REF_W);
      vmin = CFG_DATA_W'($urandom_range(0, 600000));
      vmax = CFG_DATA_W'($urandom_range(vmin, 20'hFFFFF));
      case (ph)
        0: begin
          refclk_data = CFG_DATA_W'(REFCLK_RST);
          vmin = VCO_MIN_RST;
          vmax = VCO_MAX_RST;
        end
        5: begin
          refclk_data = 20'd1000;
          vmin = 20'h00000;
          vmax = 20'hFFFFF;
        end
        6: begin
          refclk_data = 20'h1FFFF;
          vmin = 20'h00000;
          vmax = 20'hFFFFF;
        end
        default: ;
      endcase
      write_register(CFG_REFCLK, refclk_data);
      write_register(CFG_VCO_MIN, vmin);
      write_register(CFG_VCO_MAX, vmax);
      if ($urandom_range(0, 2) == 0) write_register(CFG_UNUSED, CFG_DATA_W'($urandom));
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        // long receiver hold-off so the block backs up into its input
        if (ph == 0 && k == 10) hold_requests++;
        if (ph == 1 && k == 25) wait_drained();
        send_target(pick_target(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(64'd60_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> pll_coefficient_search_unit.f
rtl/pcs_pkg.sv
rtl/pcs_divider.sv
rtl/pcs_datapath.sv
rtl/pcs_ctrl.sv
rtl/pll_coefficient_search_unit.sv
tb/sv/testbench.sv
